// ----- rtl/gtc_pkg.sv -----
// Shared constants and types of the graph three-coloring block.
// Used by gtc_adj_store, gtc_search, graph_three_coloring_top and the testbench; no dependencies.
package gtc_pkg;

  localparam int MAX_V   = 32;
  localparam int VIDX_W  = 5;   // bits of a vertex index
  localparam int CNT_W   = 6;   // bits of a vertex count, up to MAX_V
  localparam int COLOR_W = 2;

  localparam logic [CNT_W-1:0]   MAX_V_CNT = CNT_W'(MAX_V);

  localparam logic [COLOR_W-1:0] NO_COLOR = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_1  = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_2  = 2'd2;
  localparam logic [COLOR_W-1:0] COLOR_3  = 2'd3;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_START = 1'b1;

  typedef struct packed {
    logic               strobe;
    logic [VIDX_W-1:0]  vertex_id;
    logic [COLOR_W-1:0] vertex_color;
    logic               found;
    logic [COLOR_W-1:0] guard_color;
    logic [CNT_W-1:0]   guard_count;
    logic               last_flag;
  } gtc_result_t;

endpackage

// ----- rtl/gtc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module gtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gtc_adj_store.sv -----
// Adjacency row store: a RAM plus one valid bit per row, so rows read as zero
// until loaded after reset. Depends on gtc_pkg and gtc_ram.
module gtc_adj_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [gtc_pkg::VIDX_W-1:0] wr_addr,
  input  logic [gtc_pkg::MAX_V-1:0]  wr_data,
  input  logic                      rd_en,
  input  logic [gtc_pkg::VIDX_W-1:0] rd_addr,
  output logic [gtc_pkg::MAX_V-1:0]  rd_data
);
  import gtc_pkg::*;

  logic [MAX_V-1:0] row_valid;
  logic             rd_valid;
  logic [MAX_V-1:0] ram_rdata;

  gtc_ram #(
    .WIDTH (MAX_V),
    .DEPTH (MAX_V)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? ram_rdata : '0;

endmodule

// ----- rtl/gtc_search.sv -----
// Backtracking search sequencer: walks a vertex cursor, reads each adjacency
// row from the store, keeps the colors and class counts, then emits results.
// Depends on gtc_pkg.
module gtc_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [gtc_pkg::CNT_W-1:0]   n_vertices,
  output logic                        busy,
  output logic                        adj_rd_en,
  output logic [gtc_pkg::VIDX_W-1:0]  adj_rd_addr,
  input  logic [gtc_pkg::MAX_V-1:0]   adj_rd_data,
  output gtc_pkg::gtc_result_t        result
);
  import gtc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_GUARD,
    S_EMIT
  } state_t;

  state_t             state;
  logic [VIDX_W-1:0]  cursor;
  logic [CNT_W-1:0]   n_reg;
  logic [CNT_W-1:0]   cnt1;
  logic [CNT_W-1:0]   cnt2;
  logic               found_reg;
  logic [COLOR_W-1:0] gcol;
  logic [CNT_W-1:0]   gcnt;
  logic [COLOR_W-1:0] colors [MAX_V];

  logic [MAX_V-1:0]   use_mask;
  logic [MAX_V-1:0]   has1;
  logic [MAX_V-1:0]   has2;
  logic [MAX_V-1:0]   has3;
  logic               hit1;
  logic               hit2;
  logic               hit3;
  logic [COLOR_W-1:0] cur_color;
  logic [COLOR_W-1:0] pick;
  logic [CNT_W-1:0]   cnt1_next;
  logic [CNT_W-1:0]   cnt2_next;
  logic [CNT_W-1:0]   cnt3;
  logic               at_last;

  always_comb begin
    for (int i = 0; i < MAX_V; i++) begin
      use_mask[i] = (CNT_W'(i) < n_reg);
      has1[i]     = (colors[i] == COLOR_1);
      has2[i]     = (colors[i] == COLOR_2);
      has3[i]     = (colors[i] == COLOR_3);
    end
    hit1 = |(adj_rd_data & use_mask & has1);
    hit2 = |(adj_rd_data & use_mask & has2);
    hit3 = |(adj_rd_data & use_mask & has3);
    cur_color = colors[cursor];

    // Resume from the color after the current one, as the recursion does.
    pick = NO_COLOR;
    if (cur_color == NO_COLOR && !hit1) begin
      pick = COLOR_1;
    end else if ((cur_color == NO_COLOR || cur_color == COLOR_1) && !hit2) begin
      pick = COLOR_2;
    end else if (cur_color != COLOR_3 && !hit3) begin
      pick = COLOR_3;
    end

    cnt1_next = cnt1;
    cnt2_next = cnt2;
    if (cur_color == COLOR_1) begin
      cnt1_next = cnt1_next - 1'b1;
    end
    if (cur_color == COLOR_2) begin
      cnt2_next = cnt2_next - 1'b1;
    end
    if (pick == COLOR_1) begin
      cnt1_next = cnt1_next + 1'b1;
    end
    if (pick == COLOR_2) begin
      cnt2_next = cnt2_next + 1'b1;
    end

    // Uncolored vertices fall into class 3.
    cnt3    = n_reg - cnt1 - cnt2;
    at_last = ({1'b0, cursor} + 1'b1) == n_reg;
  end

  assign busy        = (state != S_IDLE);
  assign adj_rd_en   = (state == S_READ);
  assign adj_rd_addr = cursor;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      cursor           <= '0;
      n_reg            <= '0;
      cnt1             <= '0;
      cnt2             <= '0;
      result.strobe    <= 1'b0;
      result.last_flag <= 1'b0;
    end else begin
      result.strobe    <= 1'b0;
      result.last_flag <= 1'b0;
      case (state)
        S_IDLE: begin
          if (go && n_vertices != '0) begin
            for (int i = 0; i < MAX_V; i++) begin
              colors[i] <= NO_COLOR;
            end
            n_reg  <= n_vertices;
            cursor <= '0;
            cnt1   <= '0;
            cnt2   <= '0;
            state  <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          colors[cursor] <= pick;
          cnt1           <= cnt1_next;
          cnt2           <= cnt2_next;
          if (pick != NO_COLOR) begin
            if (at_last) begin
              found_reg <= 1'b1;
              state     <= S_GUARD;
            end else begin
              cursor <= cursor + 1'b1;
              state  <= S_READ;
            end
          end else if (cursor == '0) begin
            found_reg <= 1'b0;
            state     <= S_GUARD;
          end else begin
            cursor <= cursor - 1'b1;
            state  <= S_READ;
          end
        end
        S_GUARD: begin
          if (cnt1 < cnt2 && cnt1 < cnt3) begin
            gcol <= COLOR_1;
            gcnt <= cnt1;
          end else if (cnt2 < cnt1 && cnt2 < cnt3) begin
            gcol <= COLOR_2;
            gcnt <= cnt2;
          end else begin
            gcol <= COLOR_3;
            gcnt <= cnt3;
          end
          cursor <= '0;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          result.strobe       <= 1'b1;
          result.vertex_id    <= cursor;
          result.vertex_color <= colors[cursor];
          result.found        <= found_reg;
          result.last_flag    <= at_last;
          result.guard_color  <= at_last ? gcol : NO_COLOR;
          result.guard_count  <= at_last ? gcnt : '0;
          if (at_last) begin
            state <= S_IDLE;
          end else begin
            cursor <= cursor + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (({1'b0, cnt1} + {1'b0, cnt2}) <= {1'b0, n_reg}))
    else $error("color class counts exceed vertex count");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL || state == S_EMIT) |-> ({1'b0, cursor} < n_reg))
    else $error("search cursor beyond vertex count");

  a_fail_uncolored: assert property (@(posedge clk) disable iff (rst)
    (result.strobe && !result.found) |-> (result.vertex_color == NO_COLOR))
    else $error("colored vertex reported without a coloring");

  a_found_colored: assert property (@(posedge clk) disable iff (rst)
    (result.strobe && result.found) |-> (result.vertex_color != NO_COLOR))
    else $error("uncolored vertex reported with a coloring");

  a_read_then_eval: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_EVAL))
    else $error("row evaluated without a read");

endmodule

// ----- rtl/graph_three_coloring_top.sv -----
// Top level of the graph three-coloring block: command decode, vertex count
// register, adjacency store and search sequencer. Depends on gtc_pkg,
// gtc_adj_store and gtc_search.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+--------------------------------------
//   request   | start in, busy out        | req_type, row_index, row_bits
//   result    | result_strobe out         | vertex_id, vertex_color, found,
//             |                           | guard_color, guard_count, last_flag
//   config    | cfg_wr_en in              | cfg_wr_data (num_vertices)
//
// A row load leaves busy low, so loads can arrive every cycle while no search runs.
// A start request runs the search: each search step is an adjacency RAM read,
// then evaluation of all three colors; then the guard class is chosen, then
// one result per cycle for n vertices. Total time is data dependent.
// Reset clears all adjacency rows at once through per-row valid bits.
// The receiver cannot stall; results are shown for exactly one cycle each.
module graph_three_coloring_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [gtc_pkg::VIDX_W-1:0]    row_index,
  input  logic [gtc_pkg::MAX_V-1:0]     row_bits,
  input  logic                          cfg_wr_en,
  input  logic [gtc_pkg::CNT_W-1:0]     cfg_wr_data,
  output logic                          result_strobe,
  output logic [gtc_pkg::VIDX_W-1:0]    vertex_id,
  output logic [gtc_pkg::COLOR_W-1:0]   vertex_color,
  output logic                          found,
  output logic [gtc_pkg::COLOR_W-1:0]   guard_color,
  output logic [gtc_pkg::CNT_W-1:0]     guard_count,
  output logic                          last_flag
);
  import gtc_pkg::*;

  logic [CNT_W-1:0]  num_vertices;
  logic [CNT_W-1:0]  n_sat;
  logic              req_accept;
  logic              load_en;
  logic              search_go;
  logic              adj_rd_en;
  logic [VIDX_W-1:0] adj_rd_addr;
  logic [MAX_V-1:0]  adj_rd_data;
  gtc_result_t       result;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= MAX_V_CNT;
    end else if (cfg_wr_en) begin
      num_vertices <= cfg_wr_data;
    end
  end

  assign n_sat      = (num_vertices > MAX_V_CNT) ? MAX_V_CNT : num_vertices;
  assign req_accept = start && !busy;
  assign load_en    = req_accept && (req_type == REQ_LOAD);
  assign search_go  = req_accept && (req_type == REQ_START);

  gtc_adj_store u_adj (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (load_en),
    .wr_addr (row_index),
    .wr_data (row_bits),
    .rd_en   (adj_rd_en),
    .rd_addr (adj_rd_addr),
    .rd_data (adj_rd_data)
  );

  gtc_search u_search (
    .clk         (clk),
    .rst         (rst),
    .go          (search_go),
    .n_vertices  (n_sat),
    .busy        (busy),
    .adj_rd_en   (adj_rd_en),
    .adj_rd_addr (adj_rd_addr),
    .adj_rd_data (adj_rd_data),
    .result      (result)
  );

  assign result_strobe = result.strobe;
  assign vertex_id     = result.vertex_id;
  assign vertex_color  = result.vertex_color;
  assign found         = result.found;
  assign guard_color   = result.guard_color;
  assign guard_count   = result.guard_count;
  assign last_flag     = result.last_flag;

endmodule

// ----- verif/tb_graph_three_coloring_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for graph_three_coloring_top: row loads and coloring searches,
// each result checked against an in-bench backtracking predictor or a scripted expectation. Depends on gtc_pkg.
module tb_graph_three_coloring_top;
  import gtc_pkg::*;

  localparam int DIRECTED_COUNT = 25;
  localparam int RANDOM_ITEMS = 330;
  localparam int STEP_BUDGET = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int TIMEOUT_NS = 30000000;

  typedef struct packed {
    logic [VIDX_W-1:0]  vid;
    logic [COLOR_W-1:0] color;
    logic               ok;
    logic [COLOR_W-1:0] g_color;
    logic [CNT_W-1:0]   g_count;
    logic               last;
  } vertex_report_t;

  // One row of the directed script. Typed rows carry the expected outcome of a
  // start request: one color for every vertex plus the last-result fields.
  typedef struct packed {
    logic               wr_cfg;
    logic [CNT_W-1:0]   cfg_val;
    logic               kind;
    logic [VIDX_W-1:0]  row;
    logic [MAX_V-1:0]   row_data;
    logic               typed;
    logic [COLOR_W-1:0] all_color;
    logic               ok;
    logic [COLOR_W-1:0] g_color;
    logic [CNT_W-1:0]   g_count;
  } script_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                req_type = REQ_LOAD;
  logic [VIDX_W-1:0]   row_index = '0;
  logic [MAX_V-1:0]    row_bits = '0;
  logic                cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]    cfg_wr_data = '0;
  logic                result_strobe;
  logic [VIDX_W-1:0]   vertex_id;
  logic [COLOR_W-1:0]  vertex_color;
  logic                found;
  logic [COLOR_W-1:0]  guard_color;
  logic [CNT_W-1:0]    guard_count;
  logic                last_flag;

  logic [MAX_V-1:0]    row_store [MAX_V];
  logic [MAX_V-1:0]    draft_rows [MAX_V];
  logic [MAX_V-1:0]    search_rows [MAX_V];
  logic [COLOR_W-1:0]  shade [MAX_V];
  int                  vertex_total = MAX_V;
  int                  idle_pct = 0;
  int                  error_count = 0;
  vertex_report_t      pending_reports [$];
  vertex_report_t      oldest;
  script_row_t         script [DIRECTED_COUNT];

  graph_three_coloring_top dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .row_index(row_index),
    .row_bits(row_bits),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .result_strobe(result_strobe),
    .vertex_id(vertex_id),
    .vertex_color(vertex_color),
    .found(found),
    .guard_color(guard_color),
    .guard_count(guard_count),
    .last_flag(last_flag)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int live_vertices();
    return (vertex_total > MAX_V) ? MAX_V : vertex_total;
  endfunction

  function automatic bit color_fits(input int v, input int n, input int c);
    int i;
    for (i = 0; i < n; i++) begin
      if (search_rows[v][i] && int'(shade[i]) == c) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Depth-first search over vertices in index order; a cap of zero means no cap.
  function automatic bit solve_coloring(input int n, input int cap, output int steps);
    int v, c;
    bit placed;
    for (v = 0; v < MAX_V; v++) shade[v] = NO_COLOR;
    v = 0;
    steps = 0;
    while (1) begin
      steps++;
      if (cap != 0 && steps > cap) return 1'b0;
      if (v >= n) return 1'b1;
      placed = 1'b0;
      for (c = int'(shade[v]) + 1; c <= 3 && !placed; c++) begin
        if (color_fits(v, n, c)) begin
          shade[v] = COLOR_W'(c);
          placed = 1'b1;
        end
      end
      if (placed) begin
        v++;
      end else begin
        shade[v] = NO_COLOR;
        if (v == 0) return 1'b0;
        v--;
      end
    end
  endfunction

  function automatic bit search_is_cheap(input int n, input bit use_draft);
    int v, steps;
    for (v = 0; v < MAX_V; v++) search_rows[v] = use_draft ? draft_rows[v] : row_store[v];
    void'(solve_coloring(n, STEP_BUDGET, steps));
    return steps <= STEP_BUDGET;
  endfunction

  function automatic void queue_report(input int n, input int v, input logic [COLOR_W-1:0] color,
                                       input logic ok, input logic [COLOR_W-1:0] g_color,
                                       input logic [CNT_W-1:0] g_count);
    vertex_report_t r;
    r.vid = VIDX_W'(v);
    r.color = color;
    r.ok = ok;
    r.last = (v == n - 1);
    r.g_color = r.last ? g_color : NO_COLOR;
    r.g_count = r.last ? g_count : '0;
    pending_reports.push_back(r);
  endfunction

  function automatic void predict_coloring();
    int n, v, steps, s1, s2, s3;
    logic ok;
    logic [COLOR_W-1:0] g_color;
    logic [CNT_W-1:0] g_count;
    n = live_vertices();
    for (v = 0; v < MAX_V; v++) search_rows[v] = row_store[v];
    ok = solve_coloring(n, 0, steps);
    s1 = 0;
    s2 = 0;
    s3 = 0;
    for (v = 0; v < n; v++) begin
      if (shade[v] == COLOR_1) s1++;
      else if (shade[v] == COLOR_2) s2++;
      else s3++;
    end
    // Any tie for the smallest class falls through to class 3; uncolored vertices sit in class 3.
    if (s1 < s2 && s1 < s3) begin
      g_color = COLOR_1;
      g_count = CNT_W'(s1);
    end else if (s2 < s1 && s2 < s3) begin
      g_color = COLOR_2;
      g_count = CNT_W'(s2);
    end else begin
      g_color = COLOR_3;
      g_count = CNT_W'(s3);
    end
    for (v = 0; v < n; v++) queue_report(n, v, shade[v], ok, g_color, g_count);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result for vertex_id %0d", vertex_id);
        error_count++;
      end else begin
        oldest = pending_reports.pop_front();
        check_field("vertex_id", 32'(oldest.vid), 32'(vertex_id));
        check_field("vertex_color", 32'(oldest.color), 32'(vertex_color));
        check_field("found", 32'(oldest.ok), 32'(found));
        check_field("guard_color", 32'(oldest.g_color), 32'(guard_color));
        check_field("guard_count", 32'(oldest.g_count), 32'(guard_count));
        check_field("last_flag", 32'(oldest.last), 32'(last_flag));
      end
    end
  end

  task automatic sender_gap();
    int k;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      k = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (k) @(posedge clk);
    end
  endtask

  // Drives one request and returns at the edge that accepts it.
  task automatic send_request(input logic kind, input logic [VIDX_W-1:0] row,
                              input logic [MAX_V-1:0] data, input bit predicted);
    start <= 1'b1;
    req_type <= kind;
    row_index <= row;
    row_bits <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (kind == REQ_LOAD) row_store[row] = data;
    else if (predicted) predict_coloring();
  endtask

  // Loads and empty searches leave no result behind, so after the last result
  // some extra cycles pass before the block is taken as idle.
  task automatic drain_and_settle();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [CNT_W-1:0] value);
    drain_and_settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    vertex_total = int'(value);
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int idx, v, i, j, k, n, pick, flavor, tries, density, rot, random_sent;
    int hue [MAX_V];
    bit cheap;
    logic [MAX_V-1:0] low_mask;
    logic [CNT_W-1:0] count_val;
    logic [VIDX_W-1:0] pick_row;
    script_row_t p;

    for (v = 0; v < MAX_V; v++) row_store[v] = '0;
    script = '{
      '{1'b0, 6'd0,  REQ_START, 5'd0,  32'h0000_0000, 1'b1, COLOR_1,  1'b1, COLOR_3, 6'd0},
      '{1'b1, 6'd0,  REQ_START, 5'd31, 32'hFFFF_FFFF, 1'b1, NO_COLOR, 1'b0, COLOR_3, 6'd0},
      '{1'b1, 6'd63, REQ_START, 5'd0,  32'h0000_0000, 1'b1, COLOR_1,  1'b1, COLOR_3, 6'd0},
      '{1'b1, 6'd1,  REQ_START, 5'd0,  32'h0000_0000, 1'b1, COLOR_1,  1'b1, COLOR_3, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd0,  32'h0000_000E, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd1,  32'h0000_000D, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd2,  32'h0000_000B, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd3,  32'h0000_0007, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b1, 6'd4,  REQ_START, 5'd0,  32'h0000_0000, 1'b1, NO_COLOR, 1'b0, COLOR_3, 6'd4},
      '{1'b1, 6'd3,  REQ_START, 5'd0,  32'h0000_0000, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b1, 6'd2,  REQ_START, 5'd0,  32'h0000_0000, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd1,  32'h0000_0000, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd2,  32'h0000_0000, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd3,  32'h0000_0000, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd31, 32'hFFFF_FFFF, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b1, 6'd32, REQ_START, 5'd0,  32'h0000_0000, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd0,  32'h0000_0000, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd1,  32'h0000_0001, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd2,  32'h0000_0003, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd3,  32'h0000_0001, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd4,  32'h0000_0009, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b1, 6'd5,  REQ_START, 5'd0,  32'h0000_0000, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd3,  32'h0000_0000, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_LOAD,  5'd4,  32'h0000_0003, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0},
      '{1'b0, 6'd0,  REQ_START, 5'd0,  32'h0000_0000, 1'b0, NO_COLOR, 1'b0, NO_COLOR, 6'd0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed script: empty graph, zero and saturated vertex counts, a K4 that
    // cannot be colored, a lone all-ones row, and each guard class winning.
    for (idx = 0; idx < DIRECTED_COUNT; idx++) begin
      p = script[idx];
      if (p.wr_cfg) write_vertex_count(p.cfg_val);
      send_request(p.kind, p.row, p.row_data, !p.typed);
      if (p.kind == REQ_START && p.typed) begin
        n = live_vertices();
        for (v = 0; v < n; v++) queue_report(n, v, p.all_color, p.ok, p.g_color, p.g_count);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = random_sent * 3 / RANDOM_ITEMS;
      idle_pct = (pick == 1) ? 46 : (pick == 2) ? 10 : 0;
      pick = $urandom_range(99);
      if (pick < 25) begin
        pick = $urandom_range(99);
        if (pick < 8) count_val = CNT_W'($urandom_range(1, 2));
        else if (pick < 70) count_val = CNT_W'($urandom_range(3, 10));
        else if (pick < 80) count_val = CNT_W'($urandom_range(11, 31));
        else if (pick < 88) count_val = MAX_V_CNT;
        else if (pick < 94) count_val = CNT_W'($urandom_range(33, 63));
        else count_val = '0;
        write_vertex_count(count_val);
      end else if (pick < 32) begin
        drain_and_settle();
      end
      n = live_vertices();
      flavor = $urandom_range(9);
      low_mask = (n >= MAX_V) ? '1 : ((32'd1 << n) - 32'd1);
      if (flavor < 7 && n > 0) begin
        // Graph built over a hidden coloring, with stray bits above the vertex
        // count; now and then extra edges may make it uncolorable.
        cheap = 1'b0;
        for (tries = 0; tries < 4 && !cheap; tries++) begin
          for (v = 0; v < MAX_V; v++) begin
            hue[v] = $urandom_range(1, 3);
            draft_rows[v] = $urandom_range(1) ? ($urandom() & ~low_mask) : '0;
          end
          density = $urandom_range(10, 70);
          for (i = 0; i < n; i++) begin
            for (j = i + 1; j < n; j++) begin
              if (hue[i] != hue[j] && $urandom_range(99) < density) begin
                draft_rows[i][j] = 1'b1;
                if ($urandom_range(9) != 0) draft_rows[j][i] = 1'b1;
              end
            end
          end
          if ($urandom_range(3) == 0) begin
            for (k = $urandom_range(1, 3); k > 0; k--) begin
              i = $urandom_range(n - 1);
              j = $urandom_range(n - 1);
              draft_rows[i][j] = 1'b1;
              draft_rows[j][i] = 1'b1;
            end
          end
          cheap = search_is_cheap(n, 1'b1);
        end
        if (!cheap) begin
          for (v = 0; v < n; v++) draft_rows[v] = draft_rows[v] & ~low_mask;
        end
        rot = $urandom_range(n - 1);
        for (k = 0; k < n; k++) begin
          v = (k + rot) % n;
          if (n < MAX_V && $urandom_range(6) == 0) begin
            pick_row = VIDX_W'($urandom_range(n, MAX_V - 1));
            sender_gap();
            send_request(REQ_LOAD, pick_row, $urandom(), 1'b1);
            random_sent++;
          end
          sender_gap();
          send_request(REQ_LOAD, VIDX_W'(v), draft_rows[v], 1'b1);
          random_sent++;
        end
      end else begin
        // Stray loads anywhere, or a partial reload of live rows with sparse data.
        for (k = $urandom_range(1, 4); k > 0; k--) begin
          if (flavor == 9 && n > 0) pick_row = VIDX_W'($urandom_range(n - 1));
          else pick_row = VIDX_W'($urandom_range(MAX_V - 1));
          sender_gap();
          send_request(REQ_LOAD, pick_row, $urandom() & $urandom() & $urandom(), 1'b1);
          random_sent++;
        end
      end
      // A start request goes out only when the search it triggers stays short.
      if (search_is_cheap(n, 1'b0)) begin
        pick_row = VIDX_W'($urandom_range(MAX_V - 1));
        sender_gap();
        send_request(REQ_START, pick_row, $urandom(), 1'b1);
        random_sent++;
      end
    end

    drain_and_settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- graph_three_coloring_top.f -----
rtl/gtc_pkg.sv
rtl/gtc_ram.sv
rtl/gtc_adj_store.sv
rtl/gtc_search.sv
rtl/graph_three_coloring_top.sv
verif/tb_graph_three_coloring_top.sv
